// ===== design/light_sensor_poll_sequencer_core_defines.svh =====
// ----------------------------------------------------------------------------
// light_sensor_poll_sequencer_core_defines
// Assertion macros used by the checker file of the poll sequencer.
// ----------------------------------------------------------------------------
`ifndef LIGHT_SENSOR_POLL_SEQUENCER_CORE_DEFINES_SVH
`define LIGHT_SENSOR_POLL_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LSPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lsps same-cycle check failed");

// Next-cycle implication, checked out of reset
`define LSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lsps next-cycle check failed");

`endif

// ===== design/lsps_pkg.sv =====
// ----------------------------------------------------------------------------
// lsps_pkg
// Codes, widths, reset values and shared types of the light sensor poll
// sequencer.
// ----------------------------------------------------------------------------
package lsps_pkg;

    // Field widths
    localparam int KIND_W  = 3;
    localparam int ADDR_W  = 7;
    localparam int WAIT_W  = 10;
    localparam int RAW_W   = 16;
    localparam int LUX_W   = 20;
    localparam int OP_W    = 2;
    localparam int CMD_W   = 8;
    localparam int UPD_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Item kinds; the request kinds double as pending request codes
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QSAMPLE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ON      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OFF     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESET   = 3'd5;
    localparam logic [KIND_W-1:0] REQ_NONE     = 3'd0;

    // Bus operations
    localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Sensor command bytes
    localparam logic [CMD_W-1:0] CMD_HRES_ONCE  = 8'h20;
    localparam logic [CMD_W-1:0] CMD_LRES_ONCE  = 8'h23;
    localparam logic [CMD_W-1:0] CMD_DATA_RESET = 8'h07;
    localparam logic [CMD_W-1:0] CMD_SLEEP      = 8'h00;
    localparam logic [CMD_W-1:0] CMD_WAKE       = 8'h01;
    localparam logic [CMD_W-1:0] CMD_NONE       = 8'h00;

    // Reading update codes
    localparam logic [UPD_W-1:0] LUX_SAME    = 2'd0;
    localparam logic [UPD_W-1:0] LUX_NEW     = 2'd1;
    localparam logic [UPD_W-1:0] LUX_INVALID = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RES_WAIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_RES_WAIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_WAIT      = 2'd3;

    // Register reset values
    localparam logic [ADDR_W-1:0] RST_DEVICE_ADDRESS = 7'd35;
    localparam logic [WAIT_W-1:0] RST_HIGH_RES_WAIT  = 10'd185;
    localparam logic [WAIT_W-1:0] RST_LOW_RES_WAIT   = 10'd40;
    localparam logic [WAIT_W-1:0] RST_POLL_WAIT      = 10'd20;

    // Reciprocal of 3 for 16-bit operands: floor(x * RECIP3 >> RECIP3_SHIFT)
    localparam int RECIP3_SHIFT = 17;
    localparam logic [RAW_W-1:0] RECIP3 = 16'hAAAB;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_MEASURING = 4'b0010,
        ST_OFF       = 4'b0100,
        ST_ERROR     = 4'b1000
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] device_address;
        logic [WAIT_W-1:0] high_res_wait;
        logic [WAIT_W-1:0] low_res_wait;
        logic [WAIT_W-1:0] poll_wait;
    } t_cfg;

    typedef struct packed {
        logic              collision;
        logic [LUX_W-1:0]  lux_value;
        logic [UPD_W-1:0]  lux_update;
        logic [WAIT_W-1:0] wait_ms;
        logic [CMD_W-1:0]  command_byte;
        logic [ADDR_W-1:0] bus_address;
        logic [OP_W-1:0]   bus_op;
    } t_result;

endpackage

// ===== design/lsps_lux.sv =====
// ----------------------------------------------------------------------------
// lsps_lux
// Raw sensor count to lux, 4 fraction bits: floor(raw * 40 / 3).
// ----------------------------------------------------------------------------
module lsps_lux (
    input  logic [lsps_pkg::RAW_W-1:0] i_raw,
    output logic [lsps_pkg::LUX_W-1:0] o_lux
);

    // raw*40/3 = 13*raw + raw/3, remainder only in the raw/3 term
    logic [2*lsps_pkg::RAW_W-1:0] w_prod;
    logic [lsps_pkg::RAW_W-lsps_pkg::RECIP3_SHIFT+lsps_pkg::RAW_W-1:0] w_third;
    logic [lsps_pkg::LUX_W-1:0] w_x13;

    // floor(raw/3) by reciprocal multiply, exact over 16 bits
    assign w_prod  = i_raw * lsps_pkg::RECIP3;
    assign w_third = w_prod[2*lsps_pkg::RAW_W-1:lsps_pkg::RECIP3_SHIFT];

    // 13*raw as shift-add
    assign w_x13 = {1'b0, i_raw, 3'b000} + {2'b00, i_raw, 2'b00}
                 + {4'b0000, i_raw};

    assign o_lux = w_x13 + lsps_pkg::LUX_W'(w_third);

endmodule

// ===== design/lsps_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsps_ctrl
// Sequencer state, pending request and per-beat result decision.
// ----------------------------------------------------------------------------
module lsps_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [lsps_pkg::KIND_W-1:0]   i_kind,
    input  logic                          i_bus_ok,
    input  logic [lsps_pkg::LUX_W-1:0]    i_lux,
    input  lsps_pkg::t_cfg                i_cfg,
    output lsps_pkg::t_result             o_result
);

    lsps_pkg::t_state                r_state, n_state;
    logic [lsps_pkg::KIND_W-1:0]     r_pend, n_pend;
    lsps_pkg::t_result               w_res;
    logic                            w_is_req;

    assign w_is_req = (i_kind >= lsps_pkg::KIND_SAMPLE) && (i_kind <= lsps_pkg::KIND_RESET);

    // Decision for the beat in the input register
    always_comb begin
        w_res            = '0;
        w_res.bus_op     = lsps_pkg::OP_NONE;
        w_res.command_byte = lsps_pkg::CMD_NONE;
        w_res.lux_update = lsps_pkg::LUX_SAME;
        n_state          = r_state;
        n_pend           = r_pend;

        if (w_is_req) begin
            // Latch one request, refuse the rest
            if (r_pend == lsps_pkg::REQ_NONE) begin
                n_pend = i_kind;
            end else begin
                w_res.collision = 1'b1;
            end
        end else if (i_kind == lsps_pkg::KIND_TICK) begin
            w_res.wait_ms = i_cfg.poll_wait;
            unique case (r_state)
                lsps_pkg::ST_IDLE: begin
                    if (r_pend == lsps_pkg::KIND_SAMPLE || r_pend == lsps_pkg::KIND_QSAMPLE) begin
                        w_res.bus_op = lsps_pkg::OP_WRITE;
                        w_res.command_byte = (r_pend == lsps_pkg::KIND_SAMPLE) ?
                            lsps_pkg::CMD_HRES_ONCE : lsps_pkg::CMD_LRES_ONCE;
                        if (i_bus_ok) begin
                            n_state = lsps_pkg::ST_MEASURING;
                            w_res.wait_ms = (r_pend == lsps_pkg::KIND_SAMPLE) ?
                                i_cfg.high_res_wait : i_cfg.low_res_wait;
                        end else begin
                            n_state = lsps_pkg::ST_ERROR;
                            w_res.lux_update = lsps_pkg::LUX_INVALID;
                        end
                    end else if (r_pend == lsps_pkg::KIND_RESET) begin
                        w_res.bus_op       = lsps_pkg::OP_WRITE;
                        w_res.command_byte = lsps_pkg::CMD_DATA_RESET;
                        w_res.lux_update   = lsps_pkg::LUX_INVALID;
                        n_state = i_bus_ok ? lsps_pkg::ST_IDLE : lsps_pkg::ST_ERROR;
                    end else if (r_pend == lsps_pkg::KIND_OFF) begin
                        w_res.bus_op       = lsps_pkg::OP_WRITE;
                        w_res.command_byte = lsps_pkg::CMD_SLEEP;
                        w_res.lux_update   = lsps_pkg::LUX_INVALID;
                        n_state = i_bus_ok ? lsps_pkg::ST_OFF : lsps_pkg::ST_ERROR;
                    end
                    n_pend = lsps_pkg::REQ_NONE;
                end
                lsps_pkg::ST_MEASURING: begin
                    // Read the conversion; pending request waits
                    w_res.bus_op = lsps_pkg::OP_READ;
                    if (i_bus_ok) begin
                        w_res.lux_update = lsps_pkg::LUX_NEW;
                        w_res.lux_value  = i_lux;
                        n_state = lsps_pkg::ST_IDLE;
                    end else begin
                        w_res.lux_update = lsps_pkg::LUX_INVALID;
                        n_state = lsps_pkg::ST_ERROR;
                    end
                end
                lsps_pkg::ST_OFF: begin
                    if (r_pend == lsps_pkg::KIND_ON) begin
                        w_res.bus_op       = lsps_pkg::OP_WRITE;
                        w_res.command_byte = lsps_pkg::CMD_WAKE;
                        n_state = i_bus_ok ? lsps_pkg::ST_IDLE : lsps_pkg::ST_ERROR;
                    end
                    n_pend = lsps_pkg::REQ_NONE;
                end
                lsps_pkg::ST_ERROR: begin
                    // Only reset or off recover; reading left alone
                    if (r_pend == lsps_pkg::KIND_RESET) begin
                        w_res.bus_op       = lsps_pkg::OP_WRITE;
                        w_res.command_byte = lsps_pkg::CMD_DATA_RESET;
                        if (i_bus_ok) begin
                            n_state = lsps_pkg::ST_IDLE;
                        end
                    end else if (r_pend == lsps_pkg::KIND_OFF) begin
                        w_res.bus_op       = lsps_pkg::OP_WRITE;
                        w_res.command_byte = lsps_pkg::CMD_SLEEP;
                        if (i_bus_ok) begin
                            n_state = lsps_pkg::ST_OFF;
                        end
                    end
                    n_pend = lsps_pkg::REQ_NONE;
                end
                default: begin
                    n_state = lsps_pkg::ST_IDLE;
                end
            endcase
        end

        // Address shows only with a transaction
        w_res.bus_address = (w_res.bus_op != lsps_pkg::OP_NONE) ? i_cfg.device_address : '0;
    end

    // State moves once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsps_pkg::ST_IDLE;
            r_pend  <= lsps_pkg::REQ_NONE;
        end else if (i_advance) begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    assign o_result = w_res;

endmodule

// ===== design/light_sensor_poll_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// light_sensor_poll_sequencer_core
// Poll sequencer for an I2C ambient light sensor, one result beat per item.
// ----------------------------------------------------------------------------
// Every input beat (a tick or a request) yields exactly one result beat. The
// block takes one beat per clock while no result waits on m_axis_tready: a
// beat is held in the input register, the sequencer decision and the lux
// conversion run in one pass of logic, and the result lands in the output
// register. The single decision stage updates the sequencer state and
// pending request once per beat. While a finished result
// waits on m_axis_tready the input register takes one more beat and then
// holds s_axis_tready low. Configuration writes take effect at once and
// should be made while no beat is in flight.
// ----------------------------------------------------------------------------
module light_sensor_poll_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lsps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // bus_ok, read_word[15:0]
    input  logic [lsps_pkg::KIND_W-1:0]       s_axis_tuser,  // kind
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // bus_op[1:0], bus_address[6:0], command_byte[7:0], wait_ms[9:0],
    // lux_update[1:0], lux_value[19:0], collision
    output logic [55:0]                       m_axis_tdata
);

    lsps_pkg::t_cfg                   r_cfg;
    logic                             r_in_valid;
    logic [lsps_pkg::KIND_W-1:0]      r_in_kind;
    logic                             r_in_ok;
    logic [lsps_pkg::RAW_W-1:0]       r_in_raw;
    logic                             r_out_valid;
    lsps_pkg::t_result                r_out;
    lsps_pkg::t_result                w_result;
    logic [lsps_pkg::LUX_W-1:0]       w_lux;
    logic                             w_advance;
    logic                             w_s_accept;

    // Handshake
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= lsps_pkg::RST_DEVICE_ADDRESS;
            r_cfg.high_res_wait  <= lsps_pkg::RST_HIGH_RES_WAIT;
            r_cfg.low_res_wait   <= lsps_pkg::RST_LOW_RES_WAIT;
            r_cfg.poll_wait      <= lsps_pkg::RST_POLL_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lsps_pkg::CFG_DEVICE_ADDRESS:
                    r_cfg.device_address <= i_cfg_data[lsps_pkg::ADDR_W-1:0];
                lsps_pkg::CFG_HIGH_RES_WAIT: r_cfg.high_res_wait <= i_cfg_data;
                lsps_pkg::CFG_LOW_RES_WAIT:  r_cfg.low_res_wait  <= i_cfg_data;
                lsps_pkg::CFG_POLL_WAIT:     r_cfg.poll_wait     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in_kind <= s_axis_tuser;
            r_in_ok   <= s_axis_tdata[0];
            r_in_raw  <= s_axis_tdata[lsps_pkg::RAW_W:1];
        end
    end

    lsps_lux u_lux (
        .i_raw (r_in_raw),
        .o_lux (w_lux)
    );

    lsps_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_kind    (r_in_kind),
        .i_bus_ok  (r_in_ok),
        .i_lux     (w_lux),
        .i_cfg     (r_cfg),
        .o_result  (w_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_out};

endmodule

// ===== design/lsps_checker.sv =====
// ----------------------------------------------------------------------------
// lsps_checker
// Port-level checks of the poll sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "light_sensor_poll_sequencer_core_defines.svh"

module lsps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    lsps_pkg::t_result w_res;
    logic              w_hold;
    logic              w_no_op;
    logic              w_bus_quiet;
    logic              w_not_new;
    logic              w_lux_zero;
    logic              w_coll_beat;
    logic              w_coll_quiet;

    // Result fields as shown on the port
    assign w_res = m_axis_tdata[$bits(lsps_pkg::t_result)-1:0];

    assign w_hold       = m_axis_tvalid && !m_axis_tready;
    assign w_no_op      = m_axis_tvalid && (w_res.bus_op == lsps_pkg::OP_NONE);
    assign w_bus_quiet  = (w_res.bus_address == '0)
                       && (w_res.command_byte == lsps_pkg::CMD_NONE);
    assign w_not_new    = m_axis_tvalid && (w_res.lux_update != lsps_pkg::LUX_NEW);
    assign w_lux_zero   = (w_res.lux_value == '0);
    assign w_coll_beat  = m_axis_tvalid && w_res.collision;
    assign w_coll_quiet = (w_res.bus_op == lsps_pkg::OP_NONE) && (w_res.wait_ms == '0)
                       && (w_res.lux_update == lsps_pkg::LUX_SAME);

    // No transaction: no address and no command
    `LSPS_ASSERT_IMPL(a_idle_bus_quiet, i_clk, i_rst_n, w_no_op, w_bus_quiet)

    // Lux value only with a new reading
    `LSPS_ASSERT_IMPL(a_lux_only_new, i_clk, i_rst_n, w_not_new, w_lux_zero)

    // A refused request drives nothing on the bus and has no wait
    `LSPS_ASSERT_IMPL(a_collision_quiet, i_clk, i_rst_n, w_coll_beat, w_coll_quiet)

    // Stalled result beat holds
    `LSPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_hold, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind light_sensor_poll_sequencer_core lsps_checker u_lsps_checker (.*);

// ===== tb/light_sensor_poll_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// light_sensor_poll_sequencer_checker
// Watches the request/tick stream, the result stream and the register port of
// the light sensor poll sequencer. It keeps its own copy of the sequencer
// state, pending request and registers, predicts one result per accepted
// input beat, and compares each accepted result beat with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module light_sensor_poll_sequencer_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // bus_ok, read_word[15:0]
    input  logic [lsps_pkg::KIND_W-1:0]     s_axis_tuser,  // kind
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // bus_op, bus_address, command_byte, wait_ms, lux_update, lux_value, collision
    input  logic [55:0]                     m_axis_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Predicted copy of the block's state and registers
    lsps_pkg::t_cfg              sensor_cfg;
    lsps_pkg::t_state            seq_state;
    logic [lsps_pkg::KIND_W-1:0] pending_req;

    lsps_pkg::t_result expected_results[$];
    int                fail_total = 0;
    int                pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    // One sequencer step: updates the predicted state, returns the result beat
    function automatic lsps_pkg::t_result predict_sequencer_beat(
        input logic [lsps_pkg::KIND_W-1:0] kind,
        input logic                        bus_ok,
        input logic [lsps_pkg::RAW_W-1:0]  raw);
        lsps_pkg::t_result res;
        logic [31:0]       scaled;
        res = '0;
        scaled = 32'(raw) * 32'd40;
        if (kind >= lsps_pkg::KIND_SAMPLE && kind <= lsps_pkg::KIND_RESET) begin
            // Requests latch one pending slot; a second one collides
            if (pending_req == lsps_pkg::REQ_NONE) begin
                pending_req = kind;
            end else begin
                res.collision = 1'b1;
            end
        end else if (kind == lsps_pkg::KIND_TICK) begin
            res.wait_ms = sensor_cfg.poll_wait;
            case (seq_state)
                lsps_pkg::ST_IDLE: begin
                    case (pending_req)
                        lsps_pkg::KIND_SAMPLE, lsps_pkg::KIND_QSAMPLE: begin
                            res.bus_op = lsps_pkg::OP_WRITE;
                            res.command_byte = (pending_req == lsps_pkg::KIND_SAMPLE) ?
                                               lsps_pkg::CMD_HRES_ONCE :
                                               lsps_pkg::CMD_LRES_ONCE;
                            if (bus_ok) begin
                                seq_state = lsps_pkg::ST_MEASURING;
                                res.wait_ms = (pending_req == lsps_pkg::KIND_SAMPLE) ?
                                              sensor_cfg.high_res_wait :
                                              sensor_cfg.low_res_wait;
                            end else begin
                                res.lux_update = lsps_pkg::LUX_INVALID;
                                seq_state = lsps_pkg::ST_ERROR;
                            end
                        end
                        lsps_pkg::KIND_RESET: begin
                            res.bus_op = lsps_pkg::OP_WRITE;
                            res.command_byte = lsps_pkg::CMD_DATA_RESET;
                            res.lux_update = lsps_pkg::LUX_INVALID;
                            seq_state = bus_ok ? lsps_pkg::ST_IDLE : lsps_pkg::ST_ERROR;
                        end
                        lsps_pkg::KIND_OFF: begin
                            res.bus_op = lsps_pkg::OP_WRITE;
                            res.command_byte = lsps_pkg::CMD_SLEEP;
                            res.lux_update = lsps_pkg::LUX_INVALID;
                            seq_state = bus_ok ? lsps_pkg::ST_OFF : lsps_pkg::ST_ERROR;
                        end
                        default: ;
                    endcase
                    pending_req = lsps_pkg::REQ_NONE;
                end
                lsps_pkg::ST_MEASURING: begin
                    // Read back; the pending request survives this tick
                    res.bus_op = lsps_pkg::OP_READ;
                    if (bus_ok) begin
                        res.lux_update = lsps_pkg::LUX_NEW;
                        res.lux_value = lsps_pkg::LUX_W'(scaled / 32'd3);
                        seq_state = lsps_pkg::ST_IDLE;
                    end else begin
                        res.lux_update = lsps_pkg::LUX_INVALID;
                        seq_state = lsps_pkg::ST_ERROR;
                    end
                end
                lsps_pkg::ST_OFF: begin
                    if (pending_req == lsps_pkg::KIND_ON) begin
                        res.bus_op = lsps_pkg::OP_WRITE;
                        res.command_byte = lsps_pkg::CMD_WAKE;
                        seq_state = bus_ok ? lsps_pkg::ST_IDLE : lsps_pkg::ST_ERROR;
                    end
                    pending_req = lsps_pkg::REQ_NONE;
                end
                default: begin
                    // Error: only reset or off get out, reading untouched
                    if (pending_req == lsps_pkg::KIND_RESET) begin
                        res.bus_op = lsps_pkg::OP_WRITE;
                        res.command_byte = lsps_pkg::CMD_DATA_RESET;
                        if (bus_ok) seq_state = lsps_pkg::ST_IDLE;
                    end else if (pending_req == lsps_pkg::KIND_OFF) begin
                        res.bus_op = lsps_pkg::OP_WRITE;
                        res.command_byte = lsps_pkg::CMD_SLEEP;
                        if (bus_ok) seq_state = lsps_pkg::ST_OFF;
                    end
                    pending_req = lsps_pkg::REQ_NONE;
                end
            endcase
        end
        if (res.bus_op != lsps_pkg::OP_NONE) res.bus_address = sensor_cfg.device_address;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input lsps_pkg::t_result exp_r,
                                   input lsps_pkg::t_result got_r);
        fail_total++;
        if (fail_total <= REPORT_LIMIT) begin
            $display("%0t %s: exp op=%0d addr=%0d cmd=%02h wait=%0d upd=%0d lux=%0d col=%0d",
                     $realtime, what, exp_r.bus_op, exp_r.bus_address,
                     exp_r.command_byte, exp_r.wait_ms, exp_r.lux_update,
                     exp_r.lux_value, exp_r.collision);
            $display("    got op=%0d addr=%0d cmd=%02h wait=%0d upd=%0d lux=%0d col=%0d",
                     got_r.bus_op, got_r.bus_address, got_r.command_byte,
                     got_r.wait_ms, got_r.lux_update, got_r.lux_value,
                     got_r.collision);
        end
    endtask

    // Track registers, predict on input beats, compare on result beats
    always @(posedge i_clk) begin
        lsps_pkg::t_result exp_r;
        lsps_pkg::t_result got_r;
        if (!i_rst_n) begin
            sensor_cfg.device_address = lsps_pkg::RST_DEVICE_ADDRESS;
            sensor_cfg.high_res_wait  = lsps_pkg::RST_HIGH_RES_WAIT;
            sensor_cfg.low_res_wait   = lsps_pkg::RST_LOW_RES_WAIT;
            sensor_cfg.poll_wait      = lsps_pkg::RST_POLL_WAIT;
            seq_state   = lsps_pkg::ST_IDLE;
            pending_req = lsps_pkg::REQ_NONE;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lsps_pkg::CFG_DEVICE_ADDRESS:
                        sensor_cfg.device_address = i_cfg_data[lsps_pkg::ADDR_W-1:0];
                    lsps_pkg::CFG_HIGH_RES_WAIT:
                        sensor_cfg.high_res_wait  = i_cfg_data[lsps_pkg::WAIT_W-1:0];
                    lsps_pkg::CFG_LOW_RES_WAIT:
                        sensor_cfg.low_res_wait   = i_cfg_data[lsps_pkg::WAIT_W-1:0];
                    default:
                        sensor_cfg.poll_wait      = i_cfg_data[lsps_pkg::WAIT_W-1:0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_sequencer_beat(s_axis_tuser,
                                           s_axis_tdata[0], s_axis_tdata[16:1]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_r = m_axis_tdata[$bits(lsps_pkg::t_result)-1:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", '0, got_r);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r.bus_op !== exp_r.bus_op ||
                        got_r.bus_address !== exp_r.bus_address ||
                        got_r.command_byte !== exp_r.command_byte ||
                        got_r.wait_ms !== exp_r.wait_ms ||
                        got_r.lux_update !== exp_r.lux_update ||
                        got_r.lux_value !== exp_r.lux_value ||
                        got_r.collision !== exp_r.collision) begin
                        report_mismatch("result mismatch", exp_r, got_r);
                    end
                end
            end
        end
        pending_total = expected_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the light sensor poll sequencer core.
// ----------------------------------------------------------------------------
// Drives a directed walk through every sequencer state and request, then
// random request/tick traffic over several register settings (reset values,
// random, all ones, all zeros), with random stalls on both streams, a long
// result-side hold-off and pauses until all results are back. The checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lsps_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [lsps_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
    localparam int HOLD_CYCLES = 300;

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [lsps_pkg::CFG_IDX_W-1:0]  i_cfg_idx = lsps_pkg::CFG_DEVICE_ADDRESS;
    logic [lsps_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [23:0]                     s_axis_tdata = '0;  // bus_ok, read_word[15:0]
    logic [lsps_pkg::KIND_W-1:0]     s_axis_tuser = lsps_pkg::KIND_TICK;  // kind
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // bus_op, bus_address, command_byte, wait_ms, lux_update, lux_value, collision
    logic [55:0]                     m_axis_tdata;

    int fail_count;
    int pending_count;
    int send_idle_pct = 23;
    int recv_idle_pct = 64;
    int hold_ask = 0;

    light_sensor_poll_sequencer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    light_sensor_poll_sequencer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_ask) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic write_register(input logic [lsps_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lsps_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Offer one beat, with a random gap before it, and wait for acceptance
    task automatic send_beat(input logic [lsps_pkg::KIND_W-1:0] kind, input logic bus_ok,
                             input logic [lsps_pkg::RAW_W-1:0] raw);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'b0, raw, bus_ok};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Random traffic, mostly ticks and real requests, a few unused kinds
    task automatic send_random(input int count);
        int sent;
        int pick;
        logic [lsps_pkg::KIND_W-1:0] kind;
        logic [lsps_pkg::RAW_W-1:0]  raw;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 50)      kind = lsps_pkg::KIND_TICK;
            else if (pick < 64) kind = lsps_pkg::KIND_SAMPLE;
            else if (pick < 74) kind = lsps_pkg::KIND_QSAMPLE;
            else if (pick < 81) kind = lsps_pkg::KIND_ON;
            else if (pick < 88) kind = lsps_pkg::KIND_OFF;
            else if (pick < 96) kind = lsps_pkg::KIND_RESET;
            else if (pick < 98) kind = KIND_UNUSED_LO;
            else                kind = KIND_UNUSED_HI;
            case ($urandom_range(9))
                0:       raw = 16'hFFFF;
                1:       raw = 16'h0000;
                default: raw = lsps_pkg::RAW_W'($urandom);
            endcase
            send_beat(kind, $urandom_range(99) < 85, raw);
            sent++;
        end
    endtask

    task automatic run_phase(input logic [lsps_pkg::CFG_DATA_W-1:0] addr_data,
                             input logic [lsps_pkg::CFG_DATA_W-1:0] hres,
                             input logic [lsps_pkg::CFG_DATA_W-1:0] lres,
                             input logic [lsps_pkg::CFG_DATA_W-1:0] poll,
                             input int count, input bit with_hold);
        wait_drained();
        write_register(lsps_pkg::CFG_DEVICE_ADDRESS, addr_data);
        write_register(lsps_pkg::CFG_HIGH_RES_WAIT, hres);
        write_register(lsps_pkg::CFG_LOW_RES_WAIT, lres);
        write_register(lsps_pkg::CFG_POLL_WAIT, poll);
        if (with_hold) hold_ask++;
        send_random(count / 2);
        wait_drained();
        send_random(count - count / 2);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk under reset register values
        send_beat(lsps_pkg::KIND_TICK, 1'b1, 16'h1234);     // idle, nothing pending
        send_beat(KIND_UNUSED_LO, 1'b1, 16'hFFFF);          // ignored kinds
        send_beat(KIND_UNUSED_HI, 1'b0, 16'h5A5A);
        send_beat(lsps_pkg::KIND_SAMPLE, 1'b0, 16'h0000);
        send_beat(lsps_pkg::KIND_QSAMPLE, 1'b1, 16'h0000);  // collides
        send_beat(lsps_pkg::KIND_TICK, 1'b1, 16'h0000);     // high-res one-shot
        send_beat(lsps_pkg::KIND_RESET, 1'b1, 16'h0000);    // pending across the read
        send_beat(lsps_pkg::KIND_TICK, 1'b1, 16'hFFFF);     // largest lux
        send_beat(lsps_pkg::KIND_TICK, 1'b1, 16'h0000);     // reset command from idle
        send_beat(lsps_pkg::KIND_QSAMPLE, 1'b1, 16'h0000);
        send_beat(lsps_pkg::KIND_TICK, 1'b0, 16'h0000);     // failed one-shot, error
        send_beat(lsps_pkg::KIND_TICK, 1'b1, 16'h0000);     // error, nothing pending
        send_beat(lsps_pkg::KIND_RESET, 1'b1, 16'h0000);
        send_beat(lsps_pkg::KIND_TICK, 1'b0, 16'h0000);     // failed reset keeps error
        send_beat(lsps_pkg::KIND_OFF, 1'b1, 16'h0000);
        send_beat(lsps_pkg::KIND_TICK, 1'b1, 16'h0000);     // error to off
        send_beat(lsps_pkg::KIND_SAMPLE, 1'b1, 16'h0000);
        send_beat(lsps_pkg::KIND_TICK, 1'b1, 16'h0000);     // discarded while off
        send_beat(lsps_pkg::KIND_ON, 1'b1, 16'h0000);
        send_beat(lsps_pkg::KIND_TICK, 1'b0, 16'h0000);     // failed power on
        send_beat(lsps_pkg::KIND_OFF, 1'b1, 16'h0000);
        send_beat(lsps_pkg::KIND_TICK, 1'b1, 16'h0000);
        send_beat(lsps_pkg::KIND_ON, 1'b1, 16'h0000);
        send_beat(lsps_pkg::KIND_TICK, 1'b1, 16'h0000);     // back to idle
        send_beat(lsps_pkg::KIND_QSAMPLE, 1'b1, 16'h0000);
        send_beat(lsps_pkg::KIND_TICK, 1'b1, 16'h0000);     // low-res one-shot
        send_beat(lsps_pkg::KIND_TICK, 1'b1, 16'h0000);     // zero lux
        send_random(150);
        wait_drained();
        send_random(150);

        run_phase(lsps_pkg::CFG_DATA_W'($urandom), lsps_pkg::CFG_DATA_W'($urandom),
                  lsps_pkg::CFG_DATA_W'($urandom), lsps_pkg::CFG_DATA_W'($urandom),
                  310, 1'b0);
        send_idle_pct = 64;
        recv_idle_pct = 23;
        run_phase(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 310, 1'b0);
        run_phase(10'h000, 10'h000, 10'h000, 10'h000, 310, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(lsps_pkg::CFG_DATA_W'($urandom), lsps_pkg::CFG_DATA_W'($urandom),
                  lsps_pkg::CFG_DATA_W'($urandom), lsps_pkg::CFG_DATA_W'($urandom),
                  310, 1'b1);
        run_phase(lsps_pkg::CFG_DATA_W'(lsps_pkg::RST_DEVICE_ADDRESS),
                  lsps_pkg::RST_HIGH_RES_WAIT, lsps_pkg::RST_LOW_RES_WAIT,
                  lsps_pkg::RST_POLL_WAIT, 300, 1'b0);

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/lsps_pkg.sv
design/lsps_lux.sv
design/lsps_ctrl.sv
design/light_sensor_poll_sequencer_core.sv
design/lsps_checker.sv
tb/light_sensor_poll_sequencer_checker.sv
tb/testbench.sv
